/* hw/rtl/bte_pkg.sv */
// ----------------------------------------------------------------------------
// bte_pkg
// Shared types and constants for the bounded title edit match core.
// ----------------------------------------------------------------------------
package bte_pkg;

	localparam int MAX_LEN_DEF = 64;

	// input op codes
	localparam logic [1:0] OP_APPEND_FIRST  = 2'd0;
	localparam logic [1:0] OP_APPEND_SECOND = 2'd1;
	localparam logic [1:0] OP_RUN           = 2'd2;

	// register indexes
	localparam logic [1:0] REG_EXACT_LIMIT = 2'd0;
	localparam logic [1:0] REG_MID_LIMIT   = 2'd1;
	localparam logic [1:0] REG_MID_BUDGET  = 2'd2;
	localparam logic [1:0] REG_LONG_BUDGET = 2'd3;

	localparam logic [6:0] EXACT_LIMIT_RST = 7'd8;
	localparam logic [6:0] MID_LIMIT_RST   = 7'd14;
	localparam logic [3:0] MID_BUDGET_RST  = 4'd1;
	localparam logic [3:0] LONG_BUDGET_RST = 4'd2;

	typedef enum logic [1:0] {
		CMD_APPEND_FIRST,
		CMD_APPEND_SECOND,
		CMD_RUN
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [15:0] unit;
	} cmd_t;

endpackage

/* hw/rtl/bte_front.sv */
// ----------------------------------------------------------------------------
// bte_front
// Accepts input items, decodes the op and pushes commands to the queue.
// ----------------------------------------------------------------------------
module bte_front import bte_pkg::*; (
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [15:0] code_unit,
	input  logic        q_full,
	output logic        q_push,
	output cmd_t        q_cmd
);

	logic known_op;

	assign in_stall = q_full;

	always_comb begin
		known_op   = 1'b1;
		q_cmd.unit = code_unit;
		q_cmd.kind = CMD_RUN;
		unique case (op)
			OP_APPEND_FIRST:  q_cmd.kind = CMD_APPEND_FIRST;
			OP_APPEND_SECOND: q_cmd.kind = CMD_APPEND_SECOND;
			OP_RUN:           q_cmd.kind = CMD_RUN;
			default:          known_op   = 1'b0;
		endcase
	end

	// unknown op is taken and dropped
	assign q_push = in_valid && !q_full && known_op;

endmodule

/* hw/rtl/bte_queue.sv */
// ----------------------------------------------------------------------------
// bte_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module bte_queue import bte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t pop_cmd
);

	cmd_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign pop_cmd = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

/* hw/rtl/bte_back.sv */
// ----------------------------------------------------------------------------
// bte_back
// Text stores, config registers and the cell-serial bounded distance engine.
// ----------------------------------------------------------------------------
module bte_back import bte_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  cmd_t       q_cmd,
	output logic       q_pop,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       matched,
	output logic [4:0] distance,
	output logic       empty_input,
	output logic       truncated
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int CW = (LW > 7) ? LW : 7;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ROWINIT, ST_ROWRD, ST_ROWSTART, ST_CELLRD, ST_CELL, ST_DONE
	} state_t;

	state_t      state_q;
	logic [6:0]  exact_lim_q, mid_lim_q;
	logic [3:0]  mid_bud_q, long_bud_q;
	logic [LW-1:0] len_a_q, len_b_q, i_q, j_q;
	logic        ovf_q;
	logic [15:0] first_mem [MAX_LEN];
	logic [15:0] second_mem [MAX_LEN];
	logic [4:0]  row_mem [MAX_LEN + 1];
	logic [15:0] a_rd_q, b_rd_q;
	logic [4:0]  row_rd_q;
	logic [4:0]  left_q, diag_q, rmin_q, cap_q, dist_q;
	logic [3:0]  bud_q;
	logic        empty_q;
	logic        out_valid_q, matched_q, empty_out_q, trunc_q;
	logic [4:0]  dist_out_q;

	logic [CW-1:0] n_e, m_e, shorter_e, diff_e;
	logic [3:0]    bud_c;
	logic [4:0]    cell_new, new_min, sat_j, sat_i, sat_im1;
	logic          row_we;
	logic [LW-1:0] row_waddr;
	logic [4:0]    row_wdata;
	logic          load_out;

	function automatic logic [4:0] sat_cap(input logic [CW-1:0] x, input logic [4:0] cap);
		sat_cap = (x > CW'(cap)) ? cap : x[4:0];
	endfunction

	assign n_e       = CW'(len_a_q);
	assign m_e       = CW'(len_b_q);
	assign shorter_e = (n_e < m_e) ? n_e : m_e;
	assign diff_e    = (n_e > m_e) ? n_e - m_e : m_e - n_e;

	always_comb begin
		priority if (shorter_e <= CW'(exact_lim_q)) bud_c = 4'd0;
		else if (shorter_e <= CW'(mid_lim_q))       bud_c = mid_bud_q;
		else                                         bud_c = long_bud_q;
	end

	assign sat_j   = sat_cap(CW'(j_q), cap_q);
	assign sat_i   = sat_cap(CW'(i_q), cap_q);
	assign sat_im1 = sat_cap(CW'(i_q) - CW'(1), cap_q);

	// saturating min-plus cell, values never pass budget+1
	always_comb begin
		logic [4:0] best;
		logic [4:0] up;
		logic [4:0] dg;
		best = (left_q == cap_q) ? cap_q : left_q + 5'd1;
		up   = (row_rd_q == cap_q) ? cap_q : row_rd_q + 5'd1;
		dg   = (a_rd_q == b_rd_q) ? diag_q : ((diag_q == cap_q) ? cap_q : diag_q + 5'd1);
		if (up < best) best = up;
		if (dg < best) best = dg;
		cell_new = best;
	end
	assign new_min = (cell_new < rmin_q) ? cell_new : rmin_q;

	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		row_we    = 1'b0;
		row_waddr = j_q;
		row_wdata = cell_new;
		unique case (state_q)
			ST_ROWINIT: begin
				row_we    = 1'b1;
				row_wdata = sat_j;
			end
			ST_ROWSTART: begin
				row_we    = 1'b1;
				row_waddr = '0;
				row_wdata = sat_i;
			end
			ST_CELL: row_we = 1'b1;
			default: row_we = 1'b0;
		endcase
	end

	// memories: registered reads every cycle
	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.kind == CMD_APPEND_FIRST && len_a_q < LW'(MAX_LEN)) begin
			first_mem[len_a_q[AW-1:0]] <= q_cmd.unit;
		end
		if (q_pop && q_cmd.kind == CMD_APPEND_SECOND && len_b_q < LW'(MAX_LEN)) begin
			second_mem[len_b_q[AW-1:0]] <= q_cmd.unit;
		end
		if (row_we) begin
			row_mem[row_waddr] <= row_wdata;
		end
		a_rd_q   <= first_mem[AW'(i_q - LW'(1))];
		b_rd_q   <= second_mem[AW'(j_q - LW'(1))];
		row_rd_q <= row_mem[j_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			exact_lim_q <= EXACT_LIMIT_RST;
			mid_lim_q   <= MID_LIMIT_RST;
			mid_bud_q   <= MID_BUDGET_RST;
			long_bud_q  <= LONG_BUDGET_RST;
			len_a_q     <= '0;
			len_b_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_EXACT_LIMIT: exact_lim_q <= cfg_data;
					REG_MID_LIMIT:   mid_lim_q   <= cfg_data;
					REG_MID_BUDGET:  mid_bud_q   <= cfg_data[3:0];
					REG_LONG_BUDGET: long_bud_q  <= cfg_data[3:0];
				endcase
			end
			out_valid_q <= load_out || (out_valid_q && out_stall);

			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						unique case (q_cmd.kind)
							CMD_APPEND_FIRST: begin
								if (len_a_q < LW'(MAX_LEN)) len_a_q <= len_a_q + LW'(1);
								else ovf_q <= 1'b1;
							end
							CMD_APPEND_SECOND: begin
								if (len_b_q < LW'(MAX_LEN)) len_b_q <= len_b_q + LW'(1);
								else ovf_q <= 1'b1;
							end
							default: begin
								bud_q   <= bud_c;
								cap_q   <= {1'b0, bud_c} + 5'd1;
								empty_q <= (len_a_q == '0) || (len_b_q == '0);
								dist_q  <= {1'b0, bud_c} + 5'd1;
								j_q     <= '0;
								priority if ((len_a_q == '0) || (len_b_q == '0)) begin
									dist_q  <= '0;
									state_q <= ST_DONE;
								end else if (diff_e > CW'(bud_c)) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_ROWINIT;
								end
							end
						endcase
					end
				end
				ST_ROWINIT: begin
					if (j_q == len_b_q) begin
						i_q     <= LW'(1);
						state_q <= ST_ROWRD;
					end else begin
						j_q <= j_q + LW'(1);
					end
				end
				ST_ROWRD: state_q <= ST_ROWSTART;
				ST_ROWSTART: begin
					left_q  <= sat_i;
					diag_q  <= sat_im1;
					rmin_q  <= sat_i;
					j_q     <= LW'(1);
					state_q <= ST_CELLRD;
				end
				ST_CELLRD: state_q <= ST_CELL;
				ST_CELL: begin
					left_q <= cell_new;
					diag_q <= row_rd_q;
					rmin_q <= new_min;
					if (j_q == len_b_q) begin
						priority if (new_min > {1'b0, bud_q}) begin
							dist_q  <= cap_q;
							state_q <= ST_DONE;
						end else if (i_q == len_a_q) begin
							dist_q  <= cell_new;
							state_q <= ST_DONE;
						end else begin
							i_q     <= i_q + LW'(1);
							state_q <= ST_ROWRD;
						end
					end else begin
						j_q     <= j_q + LW'(1);
						state_q <= ST_CELLRD;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						matched_q   <= !empty_q && (dist_q <= {1'b0, bud_q});
						dist_out_q  <= dist_q;
						empty_out_q <= empty_q;
						trunc_q     <= ovf_q;
						len_a_q     <= '0;
						len_b_q     <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign matched     = matched_q;
	assign distance    = dist_out_q;
	assign empty_input = empty_out_q;
	assign truncated   = trunc_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(len_a_q <= LW'(MAX_LEN)) && (len_b_q <= LW'(MAX_LEN)))
		else $error("string length beyond capacity");

	a_cell_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CELL) |-> (left_q <= cap_q) && (j_q <= len_b_q) && (j_q != '0))
		else $error("cell value or column out of range");

	a_clear_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (len_a_q == '0) && (len_b_q == '0) && !ovf_q && out_valid_q)
		else $error("strings not cleared after run");

endmodule

/* hw/rtl/bounded_title_edit_match_core.sv */
// ----------------------------------------------------------------------------
// bounded_title_edit_match_core
// Bounded edit distance match of two loaded strings of 16-bit code units.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall, op, code_unit): op 0 and 1 append a unit
// to the first or second string, op 2 runs the compare, op 3 is dropped.
// Items pass through a two-entry command queue to the engine, so the input
// side keeps taking items while the engine works, until the queue is full.
// A run is computed by the single cell unit, which walks the recurrence one
// cell at a time over a one-row memory, with a read state and a compute state
// per cell; empty strings or a length gap over the budget skip the recurrence
// and go straight to the result. Output channel (out_valid/out_stall): one
// result per run, held in an output register; while the receiver stalls the
// engine waits with the next result and takes no further queued items.
// Configuration (cfg_we, cfg_index, cfg_data) is to be written only while
// idle; the block itself does not enforce this. Reset clears lengths,
// overflow flag, queue and output valid and loads the register defaults.
// ----------------------------------------------------------------------------
module bounded_title_edit_match_core import bte_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [15:0] code_unit,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        matched,
	output logic [4:0]  distance,
	output logic        empty_input,
	output logic        truncated,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	logic q_full, q_push, q_empty, q_pop;
	cmd_t push_cmd, pop_cmd;

	bte_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.code_unit (code_unit),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (push_cmd)
	);

	bte_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.pop_cmd  (pop_cmd)
	);

	bte_back #(.MAX_LEN(MAX_LEN)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_cmd       (pop_cmd),
		.q_pop       (q_pop),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.matched     (matched),
		.distance    (distance),
		.empty_input (empty_input),
		.truncated   (truncated)
	);

endmodule
